[rtl/stt_pkg.sv]
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types and constants of the source text tokenizer: character codes,
// the result record and the decode record passed between the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_COLON      = 8'h3A;
	localparam logic [7:0] CH_EQUAL      = 8'h3D;
	localparam logic [7:0] CH_BANG       = 8'h21;
	localparam logic [7:0] CH_LESS       = 8'h3C;
	localparam logic [7:0] CH_GREATER    = 8'h3E;
	localparam logic [7:0] CH_MINUS      = 8'h2D;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_TAB        = 8'h09;
	localparam logic [7:0] CH_CR         = 8'h0D;

	// Result queue depth; a power of two so the pointers wrap on their own.
	localparam int STT_QDEPTH = 4;
	localparam int STT_QIDX_W = $clog2(STT_QDEPTH);
	localparam int STT_QCNT_W = $clog2(STT_QDEPTH + 1);

	typedef struct packed {
		logic [7:0] chr;
		logic       tok_end;
		logic       run_last;
	} stt_res_t;

	typedef struct packed {
		logic [1:0] count;
		stt_res_t   r0;
		stt_res_t   r1;
		logic       pend_valid;
		logic [7:0] pend_char;
		logic       pend_word;
	} stt_dec_t;

endpackage

`default_nettype wire

[rtl/source_text_tokenizer_core.sv]
// ----------------------------------------------------------------------------
// source_text_tokenizer_core
// Streaming ASCII lexer: splits source bytes into tokens, one character per
// output transfer, flagging the last character of each token.
// ----------------------------------------------------------------------------
// The core accepts one source byte per clock while in_ready is high. A byte
// is captured in an input register, decoded in the next cycle against the
// one byte held back for lookahead, and its zero to two result characters
// enter a four-entry result queue, from whose head they leave in order. The
// output port gives one character per cycle while out_ready is high, so the
// sustained rate is one byte per cycle as long as bytes average at most one
// result each; a byte that closes a pending token and emits a token of its
// own, or completes a two-character operator, occupies the output for two
// transfers. The input register waits whenever the queue holds more than two
// results, since a byte may add two at once, and in_ready then drops. A
// held word or operator byte is released by the following byte, or at once
// when end_of_source is set on the byte just taken; whitespace never shows
// up at the output. The last result caused by each byte carries last_of_run.
// ----------------------------------------------------------------------------
`default_nettype none

module source_text_tokenizer_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] byte_in,
	input  wire logic       end_of_source,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      token_byte,
	output logic            token_end,
	output logic            last_of_run
);

	// Input register stage.
	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              eos_s1;

	// Lookahead state: the byte held back until the next byte decides it.
	logic              pend_valid_q;
	logic [7:0]        pend_char_q;
	logic              pend_word_q;

	stt_pkg::stt_dec_t dec;
	stt_pkg::stt_res_t head;
	logic              room;
	logic              advance;
	logic [1:0]        push_count;

	// The staged byte moves on once the queue can take two results.
	assign advance    = valid_s1 && room;
	assign in_ready   = !valid_s1 || room;
	assign push_count = advance ? dec.count : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= byte_in;
			eos_s1  <= end_of_source;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			pend_char_q  <= '0;
			pend_word_q  <= 1'b0;
		end else if (advance) begin
			pend_valid_q <= dec.pend_valid;
			pend_char_q  <= dec.pend_char;
			pend_word_q  <= dec.pend_word;
		end
	end

	stt_classify u_classify (
		.chr        (byte_s1),
		.eos        (eos_s1),
		.pend_valid (pend_valid_q),
		.pend_char  (pend_char_q),
		.pend_word  (pend_word_q),
		.dec        (dec)
	);

	stt_out_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_count (push_count),
		.push0      (dec.r0),
		.push1      (dec.r1),
		.room       (room),
		.head_valid (out_valid),
		.head_ready (out_ready),
		.head       (head)
	);

	assign token_byte  = head.chr;
	assign token_end   = head.tok_end;
	assign last_of_run = head.run_last;

endmodule

`default_nettype wire

[rtl/stt_classify.sv]
// ----------------------------------------------------------------------------
// stt_classify
// Combinational decode of one source byte against the held lookahead byte.
// Gives zero to two result characters and the next lookahead state.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_classify (
	input  wire logic [7:0]       chr,
	input  wire logic             eos,
	input  wire logic             pend_valid,
	input  wire logic [7:0]       pend_char,
	input  wire logic             pend_word,
	output stt_pkg::stt_dec_t     dec
);

	function automatic logic is_blank(input logic [7:0] c);
		return (c == stt_pkg::CH_SPACE) || (c >= stt_pkg::CH_TAB && c <= stt_pkg::CH_CR);
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
		       (c >= 8'h30 && c <= 8'h39) || (c == stt_pkg::CH_UNDERSCORE);
	endfunction

	function automatic logic starts_pair(input logic [7:0] c);
		return (c == stt_pkg::CH_COLON) || (c == stt_pkg::CH_EQUAL) ||
		       (c == stt_pkg::CH_BANG) || (c == stt_pkg::CH_LESS) ||
		       (c == stt_pkg::CH_GREATER) || (c == stt_pkg::CH_MINUS);
	endfunction

	function automatic logic makes_pair(input logic [7:0] a, input logic [7:0] b);
		logic eq_pair;
		eq_pair = (b == stt_pkg::CH_EQUAL) &&
		          ((a == stt_pkg::CH_COLON) || (a == stt_pkg::CH_EQUAL) ||
		           (a == stt_pkg::CH_BANG) || (a == stt_pkg::CH_LESS) ||
		           (a == stt_pkg::CH_GREATER));
		return eq_pair || (a == stt_pkg::CH_COLON && b == stt_pkg::CH_COLON) ||
		       (a == stt_pkg::CH_MINUS && b == stt_pkg::CH_GREATER);
	endfunction

	// Appends one character to the next free result slot.
	function automatic stt_pkg::stt_dec_t put(input stt_pkg::stt_dec_t d,
	                                          input logic [7:0] c, input logic e);
		stt_pkg::stt_dec_t o;
		o = d;
		if (d.count == 2'd0) begin
			o.r0.chr = c;
			o.r0.tok_end = e;
			o.count = 2'd1;
		end else begin
			o.r1.chr = c;
			o.r1.tok_end = e;
			o.count = 2'd2;
		end
		return o;
	endfunction

	// A byte seen with nothing held: drop, hold, or emit as a single token.
	function automatic stt_pkg::stt_dec_t fresh(input stt_pkg::stt_dec_t d,
	                                            input logic [7:0] c);
		stt_pkg::stt_dec_t o;
		o = d;
		if (is_blank(c)) begin
			o.pend_valid = 1'b0;
		end else if (is_word(c) || starts_pair(c)) begin
			o.pend_valid = 1'b1;
			o.pend_char = c;
			o.pend_word = is_word(c);
		end else begin
			o = put(d, c, 1'b1);
		end
		return o;
	endfunction

	always_comb begin
		stt_pkg::stt_dec_t d;
		d = '0;
		if (!pend_valid) begin
			d = fresh(d, chr);
		end else if (pend_word) begin
			if (is_word(chr)) begin
				d = put(d, pend_char, 1'b0);
				d.pend_valid = 1'b1;
				d.pend_char = chr;
				d.pend_word = 1'b1;
			end else begin
				d = put(d, pend_char, 1'b1);
				d = fresh(d, chr);
			end
		end else if (makes_pair(pend_char, chr)) begin
			d = put(d, pend_char, 1'b0);
			d = put(d, chr, 1'b1);
		end else begin
			d = put(d, pend_char, 1'b1);
			d = fresh(d, chr);
		end

		// The end of the source flushes whatever is still held.
		if (eos && d.pend_valid) begin
			d = put(d, d.pend_char, 1'b1);
			d.pend_valid = 1'b0;
			d.pend_char = '0;
			d.pend_word = 1'b0;
		end

		if (d.count == 2'd2) begin
			d.r1.run_last = 1'b1;
		end else if (d.count == 2'd1) begin
			d.r0.run_last = 1'b1;
		end
		dec = d;
	end

endmodule

`default_nettype wire

[rtl/stt_out_queue.sv]
// ----------------------------------------------------------------------------
// stt_out_queue
// Small result queue: takes up to two results per cycle, gives one per
// cycle on a valid/ready port, and reports whether two more will fit.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_out_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [1:0]         push_count,
	input  wire stt_pkg::stt_res_t  push0,
	input  wire stt_pkg::stt_res_t  push1,
	output logic                    room,
	output logic                    head_valid,
	input  wire logic               head_ready,
	output stt_pkg::stt_res_t       head
);

	stt_pkg::stt_res_t                  mem_q [stt_pkg::STT_QDEPTH];
	logic [stt_pkg::STT_QIDX_W-1:0]     wr_ptr_q;
	logic [stt_pkg::STT_QIDX_W-1:0]     rd_ptr_q;
	logic [stt_pkg::STT_QCNT_W-1:0]     count_q;
	logic                               pop;

	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign pop        = head_valid && head_ready;
	assign room       = (count_q <= stt_pkg::STT_QCNT_W'(stt_pkg::STT_QDEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_count != 2'd0) begin
			mem_q[wr_ptr_q] <= push0;
		end
		if (push_count == 2'd2) begin
			mem_q[wr_ptr_q + stt_pkg::STT_QIDX_W'(1)] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + stt_pkg::STT_QIDX_W'(push_count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + stt_pkg::STT_QIDX_W'(1);
			end
			count_q <= count_q + stt_pkg::STT_QCNT_W'(push_count)
			           - stt_pkg::STT_QCNT_W'(pop);
		end
	end

endmodule

`default_nettype wire

[rtl/stt_checker.sv]
// ----------------------------------------------------------------------------
// stt_checker
// Port-level checks of the tokenizer core, bound to every instance.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] token_byte,
	input wire logic       token_end,
	input wire logic       last_of_run
);

	// A stalled result keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(token_byte) &&
		$stable(token_end) && $stable(last_of_run))
		else $error("result changed while stalled");

	// Backpressure on the input only while results are waiting.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

	// The second result of a byte is already queued behind the first.
	a_run_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid)
		else $error("second result of a byte missing");

	// An empty output only fills from a byte taken in through the input register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a source byte");

endmodule

bind source_text_tokenizer_core stt_checker u_stt_checker (.*);

`default_nettype wire

[tb/source_text_tokenizer_core_test.sv]
// ----------------------------------------------------------------------------
// source_text_tokenizer_core_test
// Self-checking bench for the streaming tokenizer. Source bytes are sent as
// short texts of words, operators, operator pairs, stray bytes and blanks,
// and as noise. A lexer model inside the bench predicts every token
// character, and each output transfer is checked against the oldest one due.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module source_text_tokenizer_core_test;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] byte_in;
	logic       end_of_source;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] token_byte;
	logic       token_end;
	logic       last_of_run;

	source_text_tokenizer_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.byte_in       (byte_in),
		.end_of_source (end_of_source),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.token_byte    (token_byte),
		.token_end     (token_end),
		.last_of_run   (last_of_run)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Chance, in percent, that the sender or the receiver idles in a cycle.
	int send_idle_pct;
	int recv_idle_pct;

	int mismatches;
	int bytes_sent;

	// Lexer state as the bench sees it: one byte held back for lookahead.
	logic       held_valid;
	logic [7:0] held_char;
	logic       held_word;

	// Characters produced by the byte being lexed, and all characters due
	// at the output in transfer order.
	stt_pkg::stt_res_t run_chars[$];
	stt_pkg::stt_res_t token_chars_due[$];

	// ------------------------------------------------------------------
	// Character classes.
	// ------------------------------------------------------------------
	function automatic logic is_blank(logic [7:0] c);
		return c == stt_pkg::CH_SPACE || (c >= stt_pkg::CH_TAB && c <= stt_pkg::CH_CR);
	endfunction

	function automatic logic is_word_char(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
			(c >= "0" && c <= "9") || c == stt_pkg::CH_UNDERSCORE;
	endfunction

	function automatic logic may_lead_pair(logic [7:0] c);
		return c == stt_pkg::CH_COLON || c == stt_pkg::CH_EQUAL ||
			c == stt_pkg::CH_BANG || c == stt_pkg::CH_LESS ||
			c == stt_pkg::CH_GREATER || c == stt_pkg::CH_MINUS;
	endfunction

	function automatic logic forms_pair(logic [7:0] first, logic [7:0] second);
		if (second == stt_pkg::CH_EQUAL && (first == stt_pkg::CH_COLON ||
				first == stt_pkg::CH_EQUAL || first == stt_pkg::CH_BANG ||
				first == stt_pkg::CH_LESS || first == stt_pkg::CH_GREATER))
			return 1'b1;
		return (first == stt_pkg::CH_COLON && second == stt_pkg::CH_COLON) ||
			(first == stt_pkg::CH_MINUS && second == stt_pkg::CH_GREATER);
	endfunction

	// ------------------------------------------------------------------
	// Lexer model.
	// ------------------------------------------------------------------
	function automatic void put_char(logic [7:0] c, logic fin);
		stt_pkg::stt_res_t r;
		r.chr      = c;
		r.tok_end  = fin;
		r.run_last = 1'b0;
		run_chars.insert(run_chars.size(), r);
	endfunction

	function automatic void hold_char(logic [7:0] c, logic word);
		held_valid = 1'b1;
		held_char  = c;
		held_word  = word;
	endfunction

	function automatic void drop_held();
		held_valid = 1'b0;
		held_char  = 8'h00;
		held_word  = 1'b0;
	endfunction

	// A byte seen with nothing held: blanks vanish, words and possible pair
	// leaders wait for the next byte, anything else is a token right away.
	function automatic void open_token(logic [7:0] c);
		if (is_blank(c))
			return;
		if (is_word_char(c))
			hold_char(c, 1'b1);
		else if (may_lead_pair(c))
			hold_char(c, 1'b0);
		else
			put_char(c, 1'b1);
	endfunction

	function automatic void lex_byte(logic [7:0] c, logic eos);
		if (!held_valid) begin
			open_token(c);
		end else if (held_word) begin
			if (is_word_char(c)) begin
				put_char(held_char, 1'b0);
				hold_char(c, 1'b1);
			end else begin
				put_char(held_char, 1'b1);
				drop_held();
				open_token(c);
			end
		end else if (forms_pair(held_char, c)) begin
			put_char(held_char, 1'b0);
			put_char(c, 1'b1);
			drop_held();
		end else begin
			// Greedy pairing: the held operator stands alone and the new
			// byte is looked at afresh.
			put_char(held_char, 1'b1);
			drop_held();
			open_token(c);
		end

		// At the end of a source whatever is still held closes its token.
		if (eos && held_valid) begin
			put_char(held_char, 1'b1);
			drop_held();
		end

		if (run_chars.size() > 0)
			run_chars[run_chars.size() - 1].run_last = 1'b1;
		foreach (run_chars[i])
			token_chars_due.insert(token_chars_due.size(), run_chars[i]);
		run_chars.delete();
	endfunction

	// ------------------------------------------------------------------
	// Receiver: random stalls and the check of every output transfer.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		stt_pkg::stt_res_t due;
		if (arst_n && out_valid && out_ready) begin
			if (token_chars_due.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected transfer, expected none, actual %h/%b/%b",
					$time, token_byte, token_end, last_of_run);
			end else begin
				due = token_chars_due.pop_front();
				if (token_byte !== due.chr) begin
					mismatches++;
					$display("%0t: token_byte expected %h actual %h",
						$time, due.chr, token_byte);
				end
				if (token_end !== due.tok_end) begin
					mismatches++;
					$display("%0t: token_end expected %b actual %b",
						$time, due.tok_end, token_end);
				end
				if (last_of_run !== due.run_last) begin
					mismatches++;
					$display("%0t: last_of_run expected %b actual %b",
						$time, due.run_last, last_of_run);
				end
			end
		end
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// ------------------------------------------------------------------
	// Sender. Valid stays high from one byte to the next unless an idle
	// cycle is drawn, so it is never lowered and raised in one step.
	// ------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] c, input logic eos);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		byte_in       <= c;
		end_of_source <= eos;
		do
			@(posedge clk);
		while (!in_ready);
		lex_byte(c, eos);
		bytes_sent++;
	endtask

	task automatic send_text(input string s, input logic eos_on_last);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], eos_on_last && i == s.len() - 1);
	endtask

	// ------------------------------------------------------------------
	// Random source text.
	// ------------------------------------------------------------------
	function automatic logic [7:0] any_word_char();
		case ($urandom_range(0, 3))
			0: return 8'("a" + $urandom_range(0, 25));
			1: return 8'("A" + $urandom_range(0, 25));
			2: return 8'("0" + $urandom_range(0, 9));
			default: return stt_pkg::CH_UNDERSCORE;
		endcase
	endfunction

	function automatic logic [7:0] any_blank();
		if ($urandom_range(0, 5) == 0)
			return stt_pkg::CH_SPACE;
		return 8'(stt_pkg::CH_TAB + $urandom_range(0, 4));
	endfunction

	function automatic logic [7:0] any_pair_lead();
		case ($urandom_range(0, 5))
			0: return stt_pkg::CH_COLON;
			1: return stt_pkg::CH_EQUAL;
			2: return stt_pkg::CH_BANG;
			3: return stt_pkg::CH_LESS;
			4: return stt_pkg::CH_GREATER;
			default: return stt_pkg::CH_MINUS;
		endcase
	endfunction

	function automatic logic [15:0] any_op_pair();
		case ($urandom_range(0, 6))
			0: return {stt_pkg::CH_COLON, stt_pkg::CH_EQUAL};
			1: return {stt_pkg::CH_EQUAL, stt_pkg::CH_EQUAL};
			2: return {stt_pkg::CH_BANG, stt_pkg::CH_EQUAL};
			3: return {stt_pkg::CH_LESS, stt_pkg::CH_EQUAL};
			4: return {stt_pkg::CH_GREATER, stt_pkg::CH_EQUAL};
			5: return {stt_pkg::CH_COLON, stt_pkg::CH_COLON};
			default: return {stt_pkg::CH_MINUS, stt_pkg::CH_GREATER};
		endcase
	endfunction

	// Mostly well-formed texts built from tokens; some are plain noise, and
	// a few run on into the next text without an end of source.
	task automatic send_random_source();
		logic [7:0] text[$];
		logic [15:0] pair;
		int n;
		if ($urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, 12);
			repeat (n)
				text.insert(text.size(), 8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(1, 8)) begin
				case ($urandom_range(0, 9))
					0, 1, 2:
						repeat ($urandom_range(1, 6))
							text.insert(text.size(), any_word_char());
					3, 4: begin
						pair = any_op_pair();
						text.insert(text.size(), pair[15:8]);
						text.insert(text.size(), pair[7:0]);
					end
					5: text.insert(text.size(), any_pair_lead());
					6: text.insert(text.size(), 8'($urandom_range(0, 255)));
					default:
						repeat ($urandom_range(1, 2))
							text.insert(text.size(), any_blank());
				endcase
			end
		end
		foreach (text[i])
			send_byte(text[i], i == text.size() - 1 && $urandom_range(0, 9) != 0);
	endtask

	// ------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------

	// Extremes of the byte range, word growth over every word class, and a
	// byte that both closes a word and forms a token of its own.
	task automatic test_single_tokens();
		send_byte(8'h00, 1'b0);
		send_text("aZ_9", 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b1);
	endtask

	// Every two-character operator, then a leader that finds no partner and
	// a triple colon where only the first two pair up.
	task automatic test_operator_pairs();
		send_text(":===!=<=>=::->", 1'b0);
		send_text("--:::", 1'b1);
	endtask

	// Source end on a held word, on a held operator, on a blank with a word
	// held, and on a blank with nothing held.
	task automatic test_source_end();
		send_text("ab", 1'b1);
		send_byte(stt_pkg::CH_GREATER, 1'b1);
		send_byte("q", 1'b0);
		send_byte(8'h0B, 1'b1);
		send_byte(8'h0C, 1'b1);
	endtask

	task automatic test_random_sources(input int n_bytes);
		int stop_at;
		stop_at = bytes_sent + n_bytes;
		while (bytes_sent < stop_at)
			send_random_source();
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		byte_in       = 8'h00;
		end_of_source = 1'b0;
		out_ready     = 1'b0;
		send_idle_pct = 17;
		recv_idle_pct = 86;
		mismatches    = 0;
		bytes_sent    = 0;
		drop_held();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_tokens();
		test_operator_pairs();
		test_source_end();
		test_random_sources(300);

		send_idle_pct = 86;
		recv_idle_pct = 17;
		test_random_sources(310);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_sources(310);
		// Close any text left open so that a held byte is flushed too.
		send_byte(stt_pkg::CH_SPACE, 1'b1);
		in_valid <= 1'b0;

		while (token_chars_due.size() != 0)
			@(posedge clk);
		// Wait on to catch any stray transfer after the last one.
		repeat (20) @(posedge clk);

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#6_000_000;
		$display("%0t: timeout with %0d characters still due",
			$time, token_chars_due.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
